/* sv/sasb_pkg.sv */
// Shared constants and types for the straight-alpha stamp blend pipeline.
// No dependencies; imported by every module of the block.
package sasb_pkg;

    localparam int BYTE_W    = 8;
    localparam int OPAC_W    = 17;
    localparam int ALPHA_W   = 25;                 // 24 fraction bits, holds 1.0
    localparam int OA_W      = 26;
    localparam int CFG_IDX_W = 2;
    localparam int DIV_BITS  = 8;                  // quotient never exceeds 255
    localparam int REM_W     = 36;
    localparam int SIDE_LEN  = 16;                 // capture stage through divider output

    localparam logic [OPAC_W-1:0]  OPACITY_ONE = 17'd65536;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 25'd16777216;
    localparam logic [ALPHA_W-1:0] DA_STEP     = 25'd65793;     // floor(2^24 / 255)
    localparam logic [25:0]        RECIP_255   = 26'd33686018;  // floor(2^33 / 255)

    localparam logic [CFG_IDX_W-1:0] REG_OPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ERASE   = 2'd1;

    typedef struct packed {
        logic [BYTE_W-1:0] s_red;
        logic [BYTE_W-1:0] s_green;
        logic [BYTE_W-1:0] s_blue;
        logic [BYTE_W-1:0] s_alpha;
        logic [BYTE_W-1:0] d_red;
        logic [BYTE_W-1:0] d_green;
        logic [BYTE_W-1:0] d_blue;
        logic [BYTE_W-1:0] d_alpha;
        logic              last;
        logic              pass;
        logic              full;
        logic              erase;
        logic [BYTE_W-1:0] abyte;
        logic              ozero;
    } t_side;

endpackage

/* sv/sasb_alpha.sv */
// Alpha front end: source alpha, destination alpha and remaining alpha.
// Five register stages; uses sasb_pkg.
module sasb_alpha
    import sasb_pkg::*;
(
    input  logic               i_clk,
    input  logic [BYTE_W-1:0]  i_s_alpha,
    input  logic [BYTE_W-1:0]  i_d_alpha,
    input  logic [OPAC_W-1:0]  i_op,
    output logic [ALPHA_W-1:0] o_sa,
    output logic [ALPHA_W-1:0] o_t
);

    logic [ALPHA_W-1:0] r_b_x, r_c_x;
    logic [ALPHA_W-1:0] r_b_da, r_c_da, r_d_da;
    logic [50:0]        r_c_p;
    logic [ALPHA_W-1:0] r_d_sa, r_e_sa;
    logic [49:0]        r_e_tp;
    logic [ALPHA_W-1:0] r_f_t;

    logic [ALPHA_W-1:0] n_z_b, n_z_c;
    logic [16:0]        n_q;
    logic [ALPHA_W-1:0] n_r;
    logic [ALPHA_W-1:0] n_sa;
    logic [50:0]        n_tr;

    // sa = x + floor((x + 127) / 255) with x = alpha * op; the quotient by reciprocal
    assign n_z_b = r_b_x + ALPHA_W'(127);
    assign n_z_c = r_c_x + ALPHA_W'(127);
    assign n_q   = r_c_p[49:33];
    assign n_r   = n_z_c - ((ALPHA_W'(n_q) << 8) - ALPHA_W'(n_q));
    assign n_sa  = r_c_x + ALPHA_W'(n_q) + ((n_r >= ALPHA_W'(255)) ? ALPHA_W'(1) : ALPHA_W'(0));
    assign n_tr  = {1'b0, r_e_tp} + 51'd8388608;

    always_ff @(posedge i_clk) begin
        r_b_x  <= ALPHA_W'(i_s_alpha) * ALPHA_W'(i_op);
        r_b_da <= ALPHA_W'(i_d_alpha) * DA_STEP + ALPHA_W'(i_d_alpha[BYTE_W-1]);
        r_c_p  <= 51'(n_z_b) * 51'(RECIP_255);
        r_c_x  <= r_b_x;
        r_c_da <= r_b_da;
        r_d_sa <= (n_sa > ALPHA_ONE) ? ALPHA_ONE : n_sa;
        r_d_da <= r_c_da;
        r_e_tp <= 50'(r_d_da) * 50'(ALPHA_ONE - r_d_sa);
        r_e_sa <= r_d_sa;
        r_f_t  <= n_tr[48:24];
        o_sa   <= r_e_sa;
    end

    assign o_t = r_f_t;

endmodule

/* sv/sasb_div.sv */
// One color channel: weighted sum, then a restoring divide by the output
// alpha, one quotient bit per stage. Ten register stages; uses sasb_pkg.
module sasb_div
    import sasb_pkg::*;
(
    input  logic               i_clk,
    input  logic [BYTE_W-1:0]  i_s_c,
    input  logic [BYTE_W-1:0]  i_d_c,
    input  logic [ALPHA_W-1:0] i_sa,
    input  logic [ALPHA_W-1:0] i_t,
    output logic [BYTE_W-1:0]  o_q
);

    logic [REM_W-1:0]  r_ps, r_pd;
    logic [OA_W-1:0]   r_oa;
    logic [REM_W-1:0]  r_rem [0:DIV_BITS];
    logic [REM_W-1:0]  r_den [0:DIV_BITS];
    logic [BYTE_W-1:0] r_q   [0:DIV_BITS];

    always_ff @(posedge i_clk) begin
        r_ps     <= REM_W'(i_s_c) * REM_W'(i_sa);
        r_pd     <= REM_W'(i_d_c) * REM_W'(i_t);
        r_oa     <= OA_W'(i_sa) + OA_W'(i_t);
        // rounding half up: (2n + oa) / (2 oa)
        r_rem[0] <= ((r_ps + r_pd) << 1) + REM_W'(r_oa);
        r_den[0] <= REM_W'(r_oa) << 1;
        r_q[0]   <= '0;
    end

    for (genvar j = 0; j < DIV_BITS; j++) begin : g_step
        localparam int K = DIV_BITS - 1 - j;
        logic [REM_W-1:0] n_sh;
        assign n_sh = r_den[j] << K;
        always_ff @(posedge i_clk) begin
            r_den[j+1] <= r_den[j];
            if (r_rem[j] >= n_sh) begin
                r_rem[j+1] <= r_rem[j] - n_sh;
                r_q[j+1]   <= r_q[j] | (BYTE_W'(1) << K);
            end else begin
                r_rem[j+1] <= r_rem[j];
                r_q[j+1]   <= r_q[j];
            end
        end
    end

    assign o_q = r_q[DIV_BITS];

endmodule

/* sv/straight_alpha_stamp_blend_top.sv */
// Top level of the straight-alpha stamp blend: capture, side-data delay line,
// alpha front end, three channel dividers and the result select.
// Uses sasb_pkg, sasb_alpha and sasb_div.

// One pixel is taken in every cycle (busy stays low) and its result appears
// with o_done once the start beat has passed one capture stage, five stages
// of alpha arithmetic, two for the weighted color sums, eight for the
// bit-per-stage color divide and one output register. Results come out in
// order, one cycle each, and cannot be held off. Configuration writes are
// always ready and should be made only while no pixel is in flight.
module straight_alpha_stamp_blend_top
    import sasb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [BYTE_W-1:0]    i_stamp_red,
    input  logic [BYTE_W-1:0]    i_stamp_green,
    input  logic [BYTE_W-1:0]    i_stamp_blue,
    input  logic [BYTE_W-1:0]    i_stamp_alpha,
    input  logic [BYTE_W-1:0]    i_dest_red,
    input  logic [BYTE_W-1:0]    i_dest_green,
    input  logic [BYTE_W-1:0]    i_dest_blue,
    input  logic [BYTE_W-1:0]    i_dest_alpha,
    input  logic                 i_last_in_span,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [OPAC_W-1:0]    i_cfg_data,
    output logic                 o_done,
    output logic [BYTE_W-1:0]    o_out_red,
    output logic [BYTE_W-1:0]    o_out_green,
    output logic [BYTE_W-1:0]    o_out_blue,
    output logic [BYTE_W-1:0]    o_out_alpha,
    output logic                 o_pixel_changed,
    output logic                 o_last_out
);

    logic [OPAC_W-1:0]   r_opacity;
    logic                r_erase;
    logic [SIDE_LEN-1:0] r_vld;
    logic                r_o_vld;
    t_side               r_side [0:SIDE_LEN-1];
    logic [OA_W-1:0]     r_g_oa;
    logic [BYTE_W-1:0]   r_o_red, r_o_green, r_o_blue, r_o_alpha;
    logic                r_o_chg, r_o_last;

    logic [OPAC_W-1:0]   n_op;
    t_side               n_side;
    t_side               n_mid;
    logic [ALPHA_W-1:0]  w_sa, w_t;
    logic [BYTE_W-1:0]   w_q_red, w_q_green, w_q_blue;
    logic [33:0]         n_aprod;
    logic [9:0]          n_ahi;
    logic [BYTE_W-1:0]   n_abyte;
    logic [BYTE_W-1:0]   n_red, n_green, n_blue, n_alpha;
    t_side               w_end;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign n_op = (r_opacity > OPACITY_ONE) ? OPACITY_ONE : r_opacity;

    always_comb begin
        n_side         = '0;
        n_side.s_red   = i_stamp_red;
        n_side.s_green = i_stamp_green;
        n_side.s_blue  = i_stamp_blue;
        n_side.s_alpha = i_stamp_alpha;
        n_side.d_red   = i_dest_red;
        n_side.d_green = i_dest_green;
        n_side.d_blue  = i_dest_blue;
        n_side.d_alpha = i_dest_alpha;
        n_side.last    = i_last_in_span;
        n_side.pass    = (i_stamp_alpha == '0);
        n_side.full    = (i_stamp_alpha == 8'hFF) && (n_op == OPACITY_ONE);
        n_side.erase   = r_erase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opacity <= OPACITY_ONE;
            r_erase   <= 1'b0;
            r_vld     <= '0;
            r_o_vld   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_OPACITY: r_opacity <= i_cfg_data;
                    REG_ERASE:   r_erase   <= i_cfg_data[0];
                    default:     ;
                endcase
            end
            r_vld   <= {r_vld[SIDE_LEN-2:0], start};
            r_o_vld <= r_vld[SIDE_LEN-1];
        end
    end

    sasb_alpha u_alpha (
        .i_clk     (i_clk),
        .i_s_alpha (r_side[0].s_alpha),
        .i_d_alpha (r_side[0].d_alpha),
        .i_op      (n_op),
        .o_sa      (w_sa),
        .o_t       (w_t)
    );

    sasb_div u_div_red (
        .i_clk (i_clk), .i_s_c (r_side[5].s_red), .i_d_c (r_side[5].d_red),
        .i_sa  (w_sa),  .i_t   (w_t),             .o_q   (w_q_red)
    );
    sasb_div u_div_green (
        .i_clk (i_clk), .i_s_c (r_side[5].s_green), .i_d_c (r_side[5].d_green),
        .i_sa  (w_sa),  .i_t   (w_t),               .o_q   (w_q_green)
    );
    sasb_div u_div_blue (
        .i_clk (i_clk), .i_s_c (r_side[5].s_blue), .i_d_c (r_side[5].d_blue),
        .i_sa  (w_sa),  .i_t   (w_t),              .o_q   (w_q_blue)
    );

    // alpha byte = (oa * 255 + half) >> 24, clamped
    assign n_aprod = ({8'd0, r_g_oa} << 8) - 34'(r_g_oa) + 34'd8388608;
    assign n_ahi   = n_aprod[33:24];
    assign n_abyte = (n_ahi > 10'd255) ? 8'hFF : n_ahi[BYTE_W-1:0];

    always_comb begin
        n_mid       = r_side[6];
        n_mid.abyte = n_abyte;
        n_mid.ozero = (r_g_oa == '0);
    end

    always_ff @(posedge i_clk) begin
        r_side[0] <= n_side;
        for (int i = 1; i < SIDE_LEN; i++) begin
            r_side[i] <= (i == 7) ? n_mid : r_side[i-1];
        end
        r_g_oa <= r_side[5].erase ? OA_W'(w_t) : (OA_W'(w_sa) + OA_W'(w_t));
    end

    assign w_end = r_side[SIDE_LEN-1];

    always_comb begin
        if (w_end.pass) begin
            {n_red, n_green, n_blue, n_alpha} =
                {w_end.d_red, w_end.d_green, w_end.d_blue, w_end.d_alpha};
        end else if (w_end.full) begin
            if (w_end.erase) begin
                {n_red, n_green, n_blue, n_alpha} = '0;
            end else begin
                {n_red, n_green, n_blue, n_alpha} =
                    {w_end.s_red, w_end.s_green, w_end.s_blue, 8'hFF};
            end
        end else if (w_end.ozero) begin
            {n_red, n_green, n_blue, n_alpha} = '0;
        end else if (w_end.erase) begin
            {n_red, n_green, n_blue, n_alpha} =
                {w_end.d_red, w_end.d_green, w_end.d_blue, w_end.abyte};
        end else begin
            {n_red, n_green, n_blue, n_alpha} = {w_q_red, w_q_green, w_q_blue, w_end.abyte};
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_red   <= n_red;
        r_o_green <= n_green;
        r_o_blue  <= n_blue;
        r_o_alpha <= n_alpha;
        r_o_chg   <= (n_red != w_end.d_red) || (n_green != w_end.d_green) ||
                     (n_blue != w_end.d_blue) || (n_alpha != w_end.d_alpha);
        r_o_last  <= w_end.last;
    end

    assign o_done          = r_o_vld;
    assign o_out_red       = r_o_red;
    assign o_out_green     = r_o_green;
    assign o_out_blue      = r_o_blue;
    assign o_out_alpha     = r_o_alpha;
    assign o_pixel_changed = r_o_chg;
    assign o_last_out      = r_o_last;

endmodule
